FILE: hw/rtl/swm_pkg.sv
package swm_pkg;

  localparam int WINDOW_MAX_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int             CFG_W     = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVICT,
    ST_POP
  } swm_state_t;

endpackage

FILE: hw/rtl/swm_stream_if.sv
interface swm_in_if #(
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface swm_out_if #(
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] window_max;

  modport source (output valid, output window_max, input ready);
  modport sink   (input valid, input window_max, output ready);
endinterface

FILE: hw/rtl/swm_ram.sv
module swm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/swm_queue.sv
module swm_queue #(
  parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
  localparam int CNT_W = $clog2(WINDOW_MAX + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  swm_in_if.sink                         in_chan,
  input  logic [CNT_W-1:0]               win_eff,
  input  logic                           res_space,
  output logic                           res_valid,
  output logic signed [SAMPLE_WIDTH-1:0] res_value
);

  import swm_pkg::*;

  localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int POS_W  = $clog2(2 * WINDOW_MAX);
  localparam int SUM_W  = CNT_W + 1;
  localparam int WORD_W = POS_W + SAMPLE_WIDTH;

  swm_state_t state_r, state_nxt;
  logic [IDX_W-1:0]               head_r, head_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [POS_W-1:0]               pos_r, pos_nxt;
  logic [CNT_W-1:0]               fill_r, fill_nxt;
  logic [CNT_W-1:0]               win_r, win_nxt;
  logic signed [SAMPLE_WIDTH-1:0] s_r, s_nxt;
  logic signed [SAMPLE_WIDTH-1:0] hval_r, hval_nxt;

  logic                           ram_we;
  logic [IDX_W-1:0]               ram_waddr;
  logic [IDX_W-1:0]               ram_raddr;
  logic [WORD_W-1:0]              ram_rdata;
  logic signed [SAMPLE_WIDTH-1:0] rd_value;
  logic [POS_W-1:0]               rd_pos;
  logic [POS_W:0]                 age_diff;
  logic [POS_W-1:0]               age;

  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                             input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(WINDOW_MAX)) begin
      sum = sum - SUM_W'(WINDOW_MAX);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(WINDOW_MAX - 1)) ? '0 : idx + 1'b1;
  endfunction

  swm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WINDOW_MAX)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({pos_r, s_r}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_value = ram_rdata[SAMPLE_WIDTH-1:0];
  assign rd_pos   = ram_rdata[WORD_W-1:SAMPLE_WIDTH];

  // age of head candidate, modulo the position range
  always_comb begin
    age_diff = {1'b0, pos_r} - {1'b0, rd_pos};
    if (age_diff[POS_W]) begin
      age_diff = age_diff + (POS_W + 1)'(2 * WINDOW_MAX);
    end
    age = age_diff[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      count_r <= '0;
      pos_r   <= '0;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    s_r    <= s_nxt;
    hval_r <= hval_nxt;
  end

  // the write at the end of ST_POP lands before the next item's first read
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    win_nxt       = win_r;
    s_nxt         = s_r;
    hval_nxt      = hval_r;
    ram_we        = 1'b0;
    ram_waddr     = slot(head_r, count_r);
    ram_raddr     = head_r;
    in_chan.ready = 1'b0;
    res_valid     = 1'b0;
    res_value     = (count_r == '0) ? s_r : hval_r;

    unique case (state_r)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          s_nxt   = in_chan.sample;
          win_nxt = win_eff;
          if (in_chan.restart) begin
            head_nxt  = '0;
            count_nxt = '0;
            fill_nxt  = '0;
            pos_nxt   = '0;
            ram_raddr = '0;
          end
          state_nxt = ST_EVICT;
        end
      end

      ST_EVICT: begin
        if (count_r != '0 && age >= POS_W'(win_r)) begin
          head_nxt  = next_idx(head_r);
          count_nxt = count_r - 1'b1;
          ram_raddr = next_idx(head_r);
        end else begin
          hval_nxt = rd_value;
          if (count_r != '0) begin
            ram_raddr = slot(head_r, count_r - 1'b1);
          end
          state_nxt = ST_POP;
        end
      end

      ST_POP: begin
        if (count_r != '0 && rd_value <= s_r) begin
          count_nxt = count_r - 1'b1;
          if (count_r > CNT_W'(1)) begin
            ram_raddr = slot(head_r, count_r - CNT_W'(2));
          end
        end else if (res_space) begin
          ram_we    = 1'b1;
          count_nxt = count_r + 1'b1;
          pos_nxt   = (pos_r == POS_W'(2 * WINDOW_MAX - 1)) ? '0 : pos_r + 1'b1;
          if (fill_r < CNT_W'(WINDOW_MAX)) begin
            fill_nxt = fill_r + 1'b1;
          end
          res_valid = (fill_nxt >= win_r);
          state_nxt = ST_IDLE;
        end else if (count_r != '0) begin
          ram_raddr = slot(head_r, count_r - 1'b1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/sliding_window_maximum.sv
// Sliding window maximum. Each item is a signed sample plus a restart flag;
// restart empties the window before the sample is taken. The first
// window_size-1 samples of a sequence give no result, every later one gives
// the maximum of the last window_size samples. window_size 0 acts as 1,
// values above WINDOW_MAX act as WINDOW_MAX; a change takes effect at the
// next item and may only be written while the block is idle. Candidates are
// kept in a monotonic queue in one single-port-read memory, one candidate
// read per cycle. An item passes through ST_IDLE, then ST_EVICT, where
// candidates that aged out leave the head, then ST_POP, where candidates
// no greater than the sample leave the tail; each sample is dropped at most
// once. The result register lets a new item be accepted while the previous
// result waits; that item then holds in ST_POP until the register is free.
// No clearing pass is needed after reset.
module sliding_window_maximum #(
  parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  swm_in_if.sink                    in_chan,
  swm_out_if.source                 out_chan,
  input  logic                      cfg_we,
  input  logic [swm_pkg::CFG_W-1:0] cfg_wdata
);

  import swm_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);

  logic [CFG_W-1:0]               cfg_r;
  logic [CNT_W-1:0]               win_eff;
  logic                           res_space;
  logic                           res_valid;
  logic signed [SAMPLE_WIDTH-1:0] res_value;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (cfg_r == '0) begin
      win_eff = CNT_W'(1);
    end else if (32'(cfg_r) > WINDOW_MAX) begin
      win_eff = CNT_W'(WINDOW_MAX);
    end else begin
      win_eff = CNT_W'(cfg_r);
    end
  end

  swm_queue #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .win_eff   (win_eff),
    .res_space (res_space),
    .res_valid (res_valid),
    .res_value (res_value)
  );

  assign res_space = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_max_r <= res_value;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.window_max = out_max_r;

endmodule

FILE: hw/rtl/swm_check.sv
module swm_check #(
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] window_max
);

  logic       in_fire;
  logic       out_fire;
  logic [7:0] credit_r, credit_nxt;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // items accepted minus results delivered, saturating
  always_comb begin
    credit_nxt = credit_r;
    if (in_fire && !out_fire && credit_r != 8'hff) begin
      credit_nxt = credit_r + 1'b1;
    end else if (!in_fire && out_fire && credit_r != '0) begin
      credit_nxt = credit_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(window_max))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("item accepted while another is in work");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |-> credit_r != '0)
    else $error("result without an item");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sliding_window_maximum swm_check #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .window_max (out_chan.window_max)
);

FILE: tb/sliding_window_maximum_test.sv
module sliding_window_maximum_test;
  import swm_pkg::*;

  localparam int SW            = SAMPLE_WIDTH_DEF;
  localparam int WMAX          = WINDOW_MAX_DEF;
  localparam int POS_WRAP      = 2 * WMAX;
  localparam int SETTLE_CYCLES = 200;
  localparam int DRAIN_LIMIT   = 200000;
  localparam int LONG_HOLD     = 300;
  localparam int HOLD_AT_ITEM  = 30;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 restart;
  } sample_item_t;

  typedef enum int {RUN_WIDE, RUN_NARROW, RUN_EDGES, RUN_FALL, RUN_RISE} run_style_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic signed [SW-1:0] in_sample  = '0;
  logic                 in_restart = 1'b0;
  logic                 out_ready  = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata  = '0;

  swm_in_if  #(.SAMPLE_WIDTH(SW)) in_if ();
  swm_out_if #(.SAMPLE_WIDTH(SW)) out_if ();

  assign in_if.valid   = in_valid;
  assign in_if.sample  = in_sample;
  assign in_if.restart = in_restart;
  assign out_if.ready  = out_ready;

  sliding_window_maximum #(
    .WINDOW_MAX  (WMAX),
    .SAMPLE_WIDTH(SW)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  sample_item_t         sample_q[$];
  logic signed [SW-1:0] window_max_q[$];

  // monotonic candidate queue, values strictly falling from head to tail
  logic signed [SW-1:0] peak_val [WMAX];
  int                   peak_pos [WMAX];
  int                   peak_head;
  int                   peak_count;
  int                   seq_pos;
  int                   seq_fill;
  logic [CFG_W-1:0]     window_cfg;

  int                   errors    = 0;
  int                   accepted  = 0;
  int                   in_gap    = 0;
  int                   out_gap   = 0;
  int                   hold_left = 0;
  bit                   hold_done = 1'b0;
  bit                   calm      = 1'b0;
  bit                   in_acc    = 1'b0;
  sample_item_t         next_item;
  logic signed [SW-1:0] want_max;
  logic signed [SW-1:0] got_max;

  function automatic bit next_window_max(input logic signed [SW-1:0] s, input logic restart,
                                         output logic signed [SW-1:0] mx);
    int w;
    int p;
    int age;
    w = window_cfg;
    if (w < 1) w = 1;
    if (w > WMAX) w = WMAX;
    if (restart) begin
      peak_head  = 0;
      peak_count = 0;
      seq_pos    = 0;
      seq_fill   = 0;
    end
    p = seq_pos;
    while (peak_count > 0) begin
      age = (p + POS_WRAP - peak_pos[peak_head]) % POS_WRAP;
      if (age < w) break;
      peak_head = (peak_head + 1) % WMAX;
      peak_count--;
    end
    while (peak_count > 0 && peak_val[(peak_head + peak_count - 1) % WMAX] <= s)
      peak_count--;
    if (peak_count >= WMAX) begin
      peak_head = (peak_head + 1) % WMAX;
      peak_count--;
    end
    peak_val[(peak_head + peak_count) % WMAX] = s;
    peak_pos[(peak_head + peak_count) % WMAX] = p;
    peak_count++;
    seq_pos = (p + 1) % POS_WRAP;
    if (seq_fill < WMAX) seq_fill++;
    mx = peak_val[peak_head];
    return seq_fill >= w;
  endfunction

  task automatic flag_mismatch(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("mismatch %0d: %s", errors, msg);
  endtask

  always @(posedge clk) begin
    in_acc <= rst_n && in_valid && in_if.ready;
    if (!rst_n) begin
      peak_head  = 0;
      peak_count = 0;
      seq_pos    = 0;
      seq_fill   = 0;
      window_cfg <= CFG_RESET;
    end else begin
      if (cfg_we) window_cfg <= cfg_wdata;
      if (in_valid && in_if.ready) begin
        accepted++;
        if (next_window_max(in_sample, in_restart, want_max))
          window_max_q = {window_max_q, want_max};
      end
      if (out_if.valid && out_ready) begin
        got_max = out_if.window_max;
        if (window_max_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected item, window_max %0d", got_max));
        end else begin
          want_max = window_max_q.pop_front();
          if (got_max !== want_max)
            flag_mismatch($sformatf("window_max expected %0d, got %0d", want_max, got_max));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        next_item  = sample_q.pop_front();
        in_sample  <= next_item.sample;
        in_restart <= next_item.restart;
        in_valid   <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 18);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // one long hold-off early on lets the block back up into its input
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && accepted >= HOLD_AT_ITEM) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic add_item(input int v, input bit r);
    sample_item_t item;
    item.sample  = v[SW-1:0];
    item.restart = r;
    sample_q = {sample_q, item};
  endtask

  task automatic settle();
    int guard;
    guard = 0;
    while ((sample_q.size() > 0 || in_valid || window_max_q.size() > 0) && guard < DRAIN_LIMIT)
    begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // lead_fall items of a strictly falling run come first, to fill the candidate queue
  task automatic run_phase(input int win, input int n, input bit restart_first,
                           input bit allow_restart, input int lead_fall, input bit last);
    int         run_left;
    run_style_t style;
    int         v;
    int         prev;
    bit         r;
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= win[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    calm     = last;
    prev     = 30000;
    run_left = 0;
    style    = RUN_WIDE;
    for (int i = 0; i < n; i++) begin
      if (i < lead_fall) begin
        v = prev - int'($urandom_range(1, 200));
      end else begin
        if (run_left == 0) begin
          style    = run_style_t'($urandom_range(0, 4));
          run_left = $urandom_range(1, 20);
        end
        run_left--;
        case (style)
          RUN_WIDE:   v = int'($urandom_range(0, 65535)) - 32768;
          RUN_NARROW: v = int'($urandom_range(0, 6)) - 3;
          RUN_EDGES: begin
            case ($urandom_range(0, 3))
              0:       v = -32768;
              1:       v = 32767;
              2:       v = 0;
              default: v = -1;
            endcase
          end
          RUN_FALL: begin
            v = prev - int'($urandom_range(1, 300));
            if (v < -32768) v = 32767 - int'($urandom_range(0, 100));
          end
          default: begin
            v = prev + int'($urandom_range(1, 300));
            if (v > 32767) v = -32768 + int'($urandom_range(0, 100));
          end
        endcase
      end
      r = (i == 0) ? restart_first : (allow_restart && $urandom_range(0, 29) == 0);
      add_item(v, r);
      prev = v;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset window of three: extremes, ties, rising and falling runs, restarts
    add_item(32767, 1'b0);
    add_item(-32768, 1'b0);
    add_item(-32768, 1'b0);
    add_item(0, 1'b0);
    add_item(-1, 1'b0);
    add_item(-1, 1'b0);
    add_item(-1, 1'b0);
    add_item(1, 1'b1);
    add_item(2, 1'b0);
    add_item(3, 1'b0);
    add_item(3, 1'b0);
    add_item(3, 1'b0);
    add_item(-5, 1'b0);
    add_item(-6, 1'b0);
    add_item(-7, 1'b0);
    add_item(-8, 1'b0);
    add_item(32767, 1'b1);
    add_item(32767, 1'b0);
    add_item(-32768, 1'b0);
    add_item(-32768, 1'b0);
    add_item(-32768, 1'b0);
    add_item(0, 1'b0);

    run_phase(1,   30,  1'b1, 1'b1, 0,  1'b0);
    run_phase(0,   30,  1'b0, 1'b1, 0,  1'b0);
    run_phase(64,  150, 1'b1, 1'b0, 70, 1'b0);
    run_phase(5,   40,  1'b0, 1'b1, 0,  1'b0);
    run_phase(127, 100, 1'b0, 1'b0, 0,  1'b0);
    run_phase(2,   30,  1'b1, 1'b1, 0,  1'b0);
    run_phase(17,  50,  1'b0, 1'b1, 0,  1'b0);
    run_phase(3,   30,  1'b1, 1'b1, 0,  1'b0);
    run_phase(8,   40,  1'b0, 1'b1, 0,  1'b0);
    run_phase(33,  60,  1'b1, 1'b1, 0,  1'b1);
    settle();

    if (errors == 0 && window_max_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/swm_pkg.sv
hw/rtl/swm_stream_if.sv
hw/rtl/swm_ram.sv
hw/rtl/swm_queue.sv
hw/rtl/sliding_window_maximum.sv
hw/rtl/swm_check.sv
tb/sliding_window_maximum_test.sv
